// ----- rtl/bfss_pkg.sv -----
// Package of the bounded FIFO server scheduler: field widths, queue entry
// and result word layouts, saturating time add.
// No dependencies.
package bfss_pkg;

    localparam int TIME_W  = 48;
    localparam int LEN_W   = 32;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] fin;
        logic              rej;
        logic              last;
    } t_result;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [LEN_W-1:0]  b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W+1-LEN_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ----- rtl/bfss_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bfss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bfss_sched.sv -----
// Scheduler control: queue pointers, server busy time, pop loop over the
// waiting-task RAM, admit/queue/reject decision and result register.
// Depends on bfss_pkg.
module bfss_sched #(
    parameter int QUEUE_DEPTH = 16,
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int LW = (CW > bfss_pkg::LIMIT_W) ? CW : bfss_pkg::LIMIT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_req_type,
    input  logic [bfss_pkg::LEN_W-1:0]    i_arrival_time,
    input  logic [bfss_pkg::LEN_W-1:0]    i_run_length,
    input  logic [bfss_pkg::TAG_W-1:0]    i_task_tag,
    input  logic [bfss_pkg::LIMIT_W-1:0]  i_queue_limit,
    output logic                          o_res_valid,
    output bfss_pkg::t_result             o_res,
    output logic                          o_ram_we,
    output logic [PW-1:0]                 o_ram_waddr,
    output logic [bfss_pkg::ENTRY_W-1:0]  o_ram_wdata,
    output logic [PW-1:0]                 o_ram_raddr,
    input  logic [bfss_pkg::ENTRY_W-1:0]  i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_req;
    logic [bfss_pkg::LEN_W-1:0]       r_arr, r_len;
    logic [bfss_pkg::TAG_W-1:0]       r_tag;
    logic [bfss_pkg::TIME_W-1:0]      r_busy_until, n_busy_until;
    logic [PW-1:0]                    r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]                    r_count, n_count;
    logic                             r_res_valid, n_res_valid;
    bfss_pkg::t_result                r_res, n_res;

    bfss_pkg::t_entry                 w_entry;
    logic [LW-1:0]                    w_cfg_ext, w_limit;
    logic [bfss_pkg::TIME_W-1:0]      w_arr48, w_pop_fin;
    logic [CW-1:0]                    w_cnt_m1;
    logic                             w_accept, w_have, w_free, w_pop;
    logic                             w_more_pop, w_arr_res, w_room;
    logic [PW-1:0]                    w_head_inc, w_tail_inc;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_entry    = bfss_pkg::t_entry'(i_ram_rdata);
    assign w_cfg_ext  = LW'(i_queue_limit);
    assign w_limit    = (w_cfg_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : w_cfg_ext;
    assign w_arr48    = bfss_pkg::TIME_W'(r_arr);
    assign w_have     = (r_count != '0);
    assign w_free     = (r_busy_until <= w_arr48);
    assign w_pop      = (r_state == S_RUN) && w_have && (r_req || w_free);
    assign w_pop_fin  = bfss_pkg::sat_add(r_busy_until, w_entry.len);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_more_pop = (w_cnt_m1 != '0) && (r_req || (w_pop_fin <= w_arr48));
    assign w_arr_res  = !r_req && (((w_cnt_m1 == '0) && (w_pop_fin <= w_arr48))
                                   || !(LW'(w_cnt_m1) < w_limit));
    assign w_room     = (LW'(r_count) < w_limit);
    assign w_head_inc = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_tail_inc = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);

    always_comb begin
        n_state      = r_state;
        n_busy_until = r_busy_until;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_tail;
        o_ram_wdata  = {r_len, r_tag};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_pop) begin
                    n_busy_until = w_pop_fin;
                    n_head       = w_head_inc;
                    n_count      = w_cnt_m1;
                    n_res_valid  = 1'b1;
                    n_res.tag    = w_entry.tag;
                    n_res.fin    = w_pop_fin;
                    n_res.rej    = 1'b0;
                    n_res.last   = !w_more_pop && !w_arr_res;
                end else begin
                    n_state = S_IDLE;
                    if (!r_req) begin
                        priority if (!w_have && w_free) begin
                            n_busy_until = bfss_pkg::sat_add(w_arr48, r_len);
                            n_res_valid  = 1'b1;
                            n_res.tag    = r_tag;
                            n_res.fin    = bfss_pkg::sat_add(w_arr48, r_len);
                            n_res.rej    = 1'b0;
                            n_res.last   = 1'b1;
                        end else if (w_room) begin
                            o_ram_we = 1'b1;
                            n_tail   = w_tail_inc;
                            n_count  = r_count + CW'(1);
                        end else begin
                            n_res_valid = 1'b1;
                            n_res.tag   = r_tag;
                            n_res.fin   = '0;
                            n_res.rej   = 1'b1;
                            n_res.last  = 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read the entry the head will point at, so its data is ready next cycle.
    assign o_ram_raddr = n_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy_until <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy_until <= n_busy_until;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_arr <= i_arrival_time;
            r_len <= i_run_length;
            r_tag <= i_task_tag;
        end
        r_res <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("waiting count above queue depth");

    a_res_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(r_state == S_RUN))
        else $error("result word without a running item");

    a_idle_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_count) && $stable(r_head))
        else $error("queue moved while idle");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.last) |=> !r_res_valid)
        else $error("result word after last of run");

endmodule

// ----- rtl/bounded_fifo_server_scheduler_top.sv -----
// Top level of the bounded FIFO server scheduler: ports, queue limit
// register, waiting-task RAM and scheduler control.
// Depends on bfss_pkg, bfss_ram, bfss_sched.
//
//  channel  | handshake                    | words
//  ---------+------------------------------+-----------------------------------
//  request  | start, busy (take: start&!busy) | i_req_type, i_arrival_time,
//           |                              | i_run_length, i_task_tag
//  result   | o_res_valid (one cycle)      | o_done_tag, o_finish_at,
//           |                              | o_rejected, o_last_of_run
//  config   | i_cfg_valid, o_cfg_ready     | i_cfg_data (queue_limit)
//
// busy stays high while the waiting tasks are started and the request is decided, so
// a new request is not taken until the run ends; the RAM read port sets the pop
// rate of one task per cycle.
// Each result word is registered: it appears in the cycle after it is formed.
// Reset: queue empty, server free at time zero, queue_limit = 16; no clearing.
// start is ignored while busy; o_cfg_ready is high only while idle.
// The receiver cannot stall: every result word shows for exactly one cycle.
module bounded_fifo_server_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [bfss_pkg::LEN_W-1:0]    i_arrival_time,
    input  logic [bfss_pkg::LEN_W-1:0]    i_run_length,
    input  logic [bfss_pkg::TAG_W-1:0]    i_task_tag,
    output logic                          o_res_valid,
    output logic [bfss_pkg::TAG_W-1:0]    o_done_tag,
    output logic [bfss_pkg::TIME_W-1:0]   o_finish_at,
    output logic                          o_rejected,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfss_pkg::LIMIT_W-1:0]  i_cfg_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [bfss_pkg::LIMIT_W-1:0]  r_queue_limit;
    logic                          w_busy;
    bfss_pkg::t_result             w_res;
    logic                          w_ram_we;
    logic [PW-1:0]                 w_ram_waddr, w_ram_raddr;
    logic [bfss_pkg::ENTRY_W-1:0]  w_ram_wdata, w_ram_rdata;

    assign o_cfg_ready = !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= bfss_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_queue_limit <= i_cfg_data;
        end
    end

    bfss_ram #(
        .WIDTH (bfss_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bfss_sched #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_sched (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (w_busy),
        .i_req_type     (i_req_type),
        .i_arrival_time (i_arrival_time),
        .i_run_length   (i_run_length),
        .i_task_tag     (i_task_tag),
        .i_queue_limit  (r_queue_limit),
        .o_res_valid    (o_res_valid),
        .o_res          (w_res),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata)
    );

    assign busy          = w_busy;
    assign o_done_tag    = w_res.tag;
    assign o_finish_at   = w_res.fin;
    assign o_rejected    = w_res.rej;
    assign o_last_of_run = w_res.last;

endmodule
